[src/r3c_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3c_pkg
// Shared types, sizes, register indexes and coefficient helpers for the RGB
// 3x3 convolution filter.
// ----------------------------------------------------------------------------
package r3c_pkg;

    localparam int MaxWidth     = 1024;
    localparam int MaxHeight    = 1024;
    localparam int CoefBits     = 12;
    localparam int CoefFracBits = 8;
    localparam int PixMax       = 255;

    localparam int ColBits      = $clog2(MaxWidth);
    localparam int RowBits      = $clog2(MaxHeight);
    localparam int SizeBits     = 11;
    localparam int TapsABits    = 60;
    localparam int TapsBBits    = 48;
    localparam int CfgIdxBits   = 3;
    localparam int CfgDataBits  = 64;
    localparam int ProdBits     = CoefBits + 9;
    localparam int SumBits      = ProdBits + 4;
    localparam int NumTaps      = 9;

    // Register indexes of the configuration port.
    typedef enum logic [CfgIdxBits-1:0] {
        CFG_WIDTH   = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_TAPS_A  = 3'd2,
        CFG_TAPS_B  = 3'd3,
        CFG_CONTOUR = 3'd4
    } t_cfg_idx;

    typedef logic [23:0] t_pix;
    typedef logic [NumTaps-1:0][23:0] t_taps;

    typedef struct packed {
        logic [ColBits-1:0] col;
        logic [RowBits-1:0] row;
        logic               last;
    } t_job;

    // Neighbor offsets of each tap: centre, row below, same row, row above.
    localparam int TapDx [NumTaps] = '{0, -1, 0, 1, -1, 1, -1, 0, 1};
    localparam int TapDy [NumTaps] = '{0, 1, 1, 1, 0, 0, -1, -1, -1};

    // Extracts tap i from the two packed coefficient registers.
    function automatic logic signed [CoefBits-1:0] coef(
        input logic [TapsABits-1:0] taps_a,
        input logic [TapsBBits-1:0] taps_b,
        input int                   i
    );
        logic [63:0] word;
        int          k;
        word = (i < 5) ? 64'(taps_a) : 64'(taps_b);
        k    = (i < 5) ? i : i - 5;
        if (k * CoefBits >= 64) begin
            return '0;
        end
        return CoefBits'(word >> (k * CoefBits));
    endfunction

endpackage

[src/r3c_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3c_line_buf
// Three row memories, one per row slot. The slot being filled is written,
// and all three are read at the same column into a registered output.
// ----------------------------------------------------------------------------
module r3c_line_buf (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [1:0]                  i_slot,
    input  logic [r3c_pkg::ColBits-1:0] i_addr,
    input  r3c_pkg::t_pix               i_wdata,
    output logic [2:0][23:0]            o_q
);

    for (genvar b = 0; b < 3; b++) begin : g_bank
        r3c_pkg::t_pix r_mem [r3c_pkg::MaxWidth];
        r3c_pkg::t_pix r_q;

        always_ff @(posedge i_clk) begin
            if (i_en && (i_slot == 2'(b))) begin
                r_mem[i_addr] <= i_wdata;
            end
            if (i_en) begin
                r_q <= r_mem[i_addr];
            end
        end

        assign o_q[b] = r_q;
    end

endmodule

[src/r3c_job_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3c_job_seq
// Holds the 3x3 column window and issues the zero to four filter jobs that one
// pixel causes, one per cycle while the MAC is ready, with edges replicated.
// ----------------------------------------------------------------------------
module r3c_job_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load_valid,
    input  logic [r3c_pkg::ColBits-1:0] i_col,
    input  logic [r3c_pkg::RowBits-1:0] i_row,
    input  logic                        i_last_col,
    input  logic                        i_last_row,
    input  r3c_pkg::t_pix               i_top,
    input  r3c_pkg::t_pix               i_mid,
    input  r3c_pkg::t_pix               i_bot,
    output logic                        o_load,
    output logic                        o_valid,
    input  logic                        i_ready,
    output r3c_pkg::t_taps              o_taps,
    output r3c_pkg::t_job               o_job
);

    logic [3:0]                  r_mask;
    logic [r3c_pkg::ColBits-1:0] r_col;
    logic [r3c_pkg::RowBits-1:0] r_row;
    logic                        r_last_col;
    logic                        r_last_row;
    logic [2:0][2:0][23:0]       r_win;

    logic [3:0] pick;
    logic [3:0] rest;
    logic [3:0] n_mask;
    logic       xs;
    logic       ys;
    logic       left;
    logic       right;
    logic       up;
    logic       down;
    logic       issue;
    r3c_pkg::t_pix centre;

    always_comb begin
        priority if (r_mask[0]) begin
            pick = 4'b0001;
        end else if (r_mask[1]) begin
            pick = 4'b0010;
        end else if (r_mask[2]) begin
            pick = 4'b0100;
        end else begin
            pick = 4'b1000;
        end
    end

    assign rest    = r_mask & ~pick;
    assign o_valid = (r_mask != 4'b0);
    assign issue   = o_valid && i_ready;
    assign o_load  = i_load_valid && (!o_valid || (issue && (rest == 4'b0)));

    // Jobs are ordered: left column (upper row, last row), then right column.
    assign xs    = pick[2] | pick[3];
    assign ys    = pick[1] | pick[3];
    assign left  = xs ? (r_col == '0) : (r_col == r3c_pkg::ColBits'(1));
    assign right = xs;
    assign up    = ys ? (r_row == '0) : (r_row == r3c_pkg::RowBits'(1));
    assign down  = ys;
    assign centre = r_win[{1'b0, xs} + 2'd1][{1'b0, ys} + 2'd1];

    always_comb begin
        int  dx;
        int  dy;
        logic outside;
        logic [1:0] ci;
        logic [1:0] ri;
        for (int t = 0; t < r3c_pkg::NumTaps; t++) begin
            dx      = r3c_pkg::TapDx[t];
            dy      = r3c_pkg::TapDy[t];
            outside = ((dx == -1) && left) || ((dx == 1) && right) ||
                      ((dy == -1) && up) || ((dy == 1) && down);
            ci      = 2'(dx + 1 + int'(xs));
            ri      = 2'(dy + 1 + int'(ys));
            if (outside || (ci == 2'd3) || (ri == 2'd3)) begin
                o_taps[t] = centre;
            end else begin
                o_taps[t] = r_win[ci][ri];
            end
        end
    end

    assign o_job.col  = xs ? r_col : r_col - r3c_pkg::ColBits'(1);
    assign o_job.row  = ys ? r_row : r_row - r3c_pkg::RowBits'(1);
    assign o_job.last = (rest == 4'b0);

    always_comb begin
        n_mask = r_mask;
        if (o_load) begin
            n_mask[0] = (i_col != '0) && (i_row != '0);
            n_mask[1] = (i_col != '0) && i_last_row;
            n_mask[2] = i_last_col && (i_row != '0);
            n_mask[3] = i_last_col && i_last_row;
        end else if (issue) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_col      <= i_col;
            r_row      <= i_row;
            r_last_col <= i_last_col;
            r_last_row <= i_last_row;
            r_win[0]   <= r_win[1];
            r_win[1]   <= r_win[2];
            r_win[2]   <= {i_bot, i_mid, i_top};
        end
    end

    // The job flags follow from the stored position.
`ifndef SYNTH
    a_right_job_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask[2] || r_mask[3]) |-> r_last_col)
        else $error("right-column job without row end");
    a_last_row_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask[1] || r_mask[3]) |-> r_last_row)
        else $error("last-row job outside last row");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> ($past(rest) == 4'b0 || !$past(o_valid)))
        else $error("window reloaded while jobs pending");
`endif

endmodule

[src/r3c_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3c_mac
// Three-stage filter datapath: tap register, nine products per channel,
// then sum, floor, clamp and contour pass-through into the output register.
// ----------------------------------------------------------------------------
module r3c_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  r3c_pkg::t_taps                i_taps,
    input  r3c_pkg::t_job                 i_job,
    input  logic [r3c_pkg::TapsABits-1:0] i_taps_a,
    input  logic [r3c_pkg::TapsBBits-1:0] i_taps_b,
    input  logic                          i_contour,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0][7:0]               o_rgb,
    output r3c_pkg::t_job                 o_job
);

    logic           r_m_valid;
    r3c_pkg::t_taps r_m_taps;
    r3c_pkg::t_job  r_m_job;

    logic                                  r_p_valid;
    logic signed [r3c_pkg::ProdBits-1:0]   r_p_prod [3][r3c_pkg::NumTaps];
    logic [2:0]                            r_p_flat;
    logic [2:0][7:0]                       r_p_centre;
    r3c_pkg::t_job                         r_p_job;

    logic            r_o_valid;
    logic [2:0][7:0] r_o_rgb;
    r3c_pkg::t_job   r_o_job;

    logic m_ready;
    logic p_ready;
    logic o_adv;

    logic signed [r3c_pkg::ProdBits-1:0] n_prod [3][r3c_pkg::NumTaps];
    logic [2:0]                          n_flat;
    logic [2:0][7:0]                     n_centre;
    logic [2:0][7:0]                     n_rgb;

    assign o_adv   = !r_o_valid || i_ready;
    assign p_ready = !r_p_valid || o_adv;
    assign m_ready = !r_m_valid || p_ready;
    assign o_ready = m_ready;

    always_comb begin
        logic signed [r3c_pkg::CoefBits-1:0] c;
        logic [7:0] v;
        for (int ch = 0; ch < 3; ch++) begin
            n_centre[ch] = r_m_taps[0][23 - 8*ch -: 8];
            n_flat[ch]   = 1'b1;
            for (int t = 0; t < r3c_pkg::NumTaps; t++) begin
                c = r3c_pkg::coef(i_taps_a, i_taps_b, t);
                v = r_m_taps[t][23 - 8*ch -: 8];
                if (v != n_centre[ch]) begin
                    n_flat[ch] = 1'b0;
                end
                n_prod[ch][t] = $signed({1'b0, v}) * c;
            end
        end
    end

    always_comb begin
        logic signed [r3c_pkg::SumBits-1:0] sum;
        logic signed [r3c_pkg::SumBits-1:0] shifted;
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int t = 0; t < r3c_pkg::NumTaps; t++) begin
                sum = sum + r3c_pkg::SumBits'(r_p_prod[ch][t]);
            end
            shifted = sum >>> r3c_pkg::CoefFracBits;
            if (i_contour && r_p_flat[ch]) begin
                n_rgb[ch] = r_p_centre[ch];
            end else if (sum < 0) begin
                n_rgb[ch] = 8'd0;
            end else if (shifted > r3c_pkg::SumBits'(r3c_pkg::PixMax)) begin
                n_rgb[ch] = 8'(r3c_pkg::PixMax);
            end else begin
                n_rgb[ch] = shifted[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (m_ready) begin
                r_m_valid <= i_valid;
            end
            if (p_ready) begin
                r_p_valid <= r_m_valid;
            end
            if (o_adv) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && i_valid) begin
            r_m_taps <= i_taps;
            r_m_job  <= i_job;
        end
        if (p_ready && r_m_valid) begin
            r_p_prod   <= n_prod;
            r_p_flat   <= n_flat;
            r_p_centre <= n_centre;
            r_p_job    <= r_m_job;
        end
        if (o_adv && r_p_valid) begin
            r_o_rgb <= n_rgb;
            r_o_job <= r_p_job;
        end
    end

    assign o_valid = r_o_valid;
    assign o_rgb   = r_o_rgb;
    assign o_job   = r_o_job;

endmodule

[src/rgb_3x3_convolution_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_filter
// Streaming 3x3 RGB convolution with edge replication, floor and clamp.
// ----------------------------------------------------------------------------
// Pixels enter in row order at one per clock unless the input is held. Three
// row memories hold the current row and the two above it; each accepted pixel
// is written into its row slot while the two rows above are read at the same
// column, and the returned column is shifted into a 3x3 window. Pixel (x,y)
// is filtered once (x+1,y+1) has arrived, so results run one row behind;
// pixels of the last row come out with the row above. Most pixels cause
// exactly one result, and then the input is taken every cycle unless the
// output stalls. A pixel at the end of a row or in the last row causes up to
// four results, and the job sequencer that issues them one per cycle while
// the pipeline is ready holds the input until the last one is issued. Results
// leave through a three-stage multiply and clamp pipeline ending in an output
// register. A result whose transaction is held by the output side does not
// stop the pipeline stages behind it until they fill. No clearing pass after
// reset is needed: a memory entry read before it was written is always
// replaced by the centre pixel. The user must see that configuration is
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_in_red,
    input  logic [7:0]                       i_in_green,
    input  logic [7:0]                       i_in_blue,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_out_red,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_blue,
    output logic [9:0]                       o_out_column,
    output logic [9:0]                       o_out_row,
    output logic                             o_run_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [r3c_pkg::CfgIdxBits-1:0]   i_cfg_index,
    input  logic [r3c_pkg::CfgDataBits-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [r3c_pkg::SizeBits-1:0]  r_cfg_width;
    logic [r3c_pkg::SizeBits-1:0]  r_cfg_height;
    logic [r3c_pkg::TapsABits-1:0] r_cfg_taps_a;
    logic [r3c_pkg::TapsBBits-1:0] r_cfg_taps_b;
    logic                          r_cfg_contour;

    // Position of the next pixel and its row slot.
    logic [r3c_pkg::ColBits-1:0] r_col;
    logic [r3c_pkg::RowBits-1:0] r_row;
    logic [1:0]                  r_slot;

    // Stage that waits for the row memory read data.
    logic                        r_s1_valid;
    logic [r3c_pkg::ColBits-1:0] r_s1_col;
    logic [r3c_pkg::RowBits-1:0] r_s1_row;
    logic [1:0]                  r_s1_slot;
    logic                        r_s1_last_col;
    logic                        r_s1_last_row;
    r3c_pkg::t_pix               r_s1_pix;

    logic [r3c_pkg::SizeBits-1:0] w_size;
    logic [r3c_pkg::SizeBits-1:0] h_size;
    logic                         in_acc;
    logic                         cfg_acc;
    logic                         restart;
    logic [r3c_pkg::ColBits-1:0]  cur_col;
    logic [r3c_pkg::RowBits-1:0]  cur_row;
    logic [1:0]                   cur_slot;
    logic [r3c_pkg::SizeBits-1:0] col_inc;
    logic [r3c_pkg::SizeBits-1:0] row_inc;
    logic [r3c_pkg::ColBits-1:0]  n_col;
    logic [r3c_pkg::RowBits-1:0]  n_row;
    logic [1:0]                   n_slot;
    logic                         s1_adv;
    logic [2:0][23:0]             mem_q;
    r3c_pkg::t_pix                row_top;
    r3c_pkg::t_pix                row_mid;

    logic           job_valid;
    logic           mac_ready;
    r3c_pkg::t_taps job_taps;
    r3c_pkg::t_job  job_info;
    logic [2:0][7:0] res_rgb;
    r3c_pkg::t_job  res_job;

    // Sizes saturate into 1..MaxWidth and 1..MaxHeight.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_size = r3c_pkg::SizeBits'(1);
        end else if (r_cfg_width > r3c_pkg::SizeBits'(r3c_pkg::MaxWidth)) begin
            w_size = r3c_pkg::SizeBits'(r3c_pkg::MaxWidth);
        end else begin
            w_size = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            h_size = r3c_pkg::SizeBits'(1);
        end else if (r_cfg_height > r3c_pkg::SizeBits'(r3c_pkg::MaxHeight)) begin
            h_size = r3c_pkg::SizeBits'(r3c_pkg::MaxHeight);
        end else begin
            h_size = r_cfg_height;
        end
    end

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= r3c_pkg::SizeBits'(640);
            r_cfg_height  <= r3c_pkg::SizeBits'(480);
            r_cfg_taps_a  <= r3c_pkg::TapsABits'(256);
            r_cfg_taps_b  <= '0;
            r_cfg_contour <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                r3c_pkg::CFG_WIDTH:   r_cfg_width   <= i_cfg_data[r3c_pkg::SizeBits-1:0];
                r3c_pkg::CFG_HEIGHT:  r_cfg_height  <= i_cfg_data[r3c_pkg::SizeBits-1:0];
                r3c_pkg::CFG_TAPS_A:  r_cfg_taps_a  <= i_cfg_data[r3c_pkg::TapsABits-1:0];
                r3c_pkg::CFG_TAPS_B:  r_cfg_taps_b  <= i_cfg_data[r3c_pkg::TapsBBits-1:0];
                r3c_pkg::CFG_CONTOUR: r_cfg_contour <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A new pixel is taken whenever the read stage is empty or moves on.
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    // Once a size is at or below the position, the frame restarts at (0,0).
    assign restart  = (r3c_pkg::SizeBits'(r_col) >= w_size) ||
                      (r3c_pkg::SizeBits'(r_row) >= h_size);
    assign cur_col  = restart ? '0 : r_col;
    assign cur_row  = restart ? '0 : r_row;
    assign cur_slot = restart ? 2'd0 : r_slot;
    assign col_inc  = r3c_pkg::SizeBits'(cur_col) + r3c_pkg::SizeBits'(1);
    assign row_inc  = r3c_pkg::SizeBits'(cur_row) + r3c_pkg::SizeBits'(1);

    always_comb begin
        n_col  = col_inc[r3c_pkg::ColBits-1:0];
        n_row  = cur_row;
        n_slot = cur_slot;
        if (col_inc >= w_size) begin
            n_col = '0;
            if (row_inc >= h_size) begin
                n_row  = '0;
                n_slot = 2'd0;
            end else begin
                n_row  = row_inc[r3c_pkg::RowBits-1:0];
                n_slot = (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_slot     <= 2'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col      <= cur_col;
            r_s1_row      <= cur_row;
            r_s1_slot     <= cur_slot;
            r_s1_last_col <= (col_inc == w_size);
            r_s1_last_row <= (row_inc == h_size);
            r_s1_pix      <= {i_in_red, i_in_green, i_in_blue};
        end
    end

    // The read data register only changes on a new transaction, so it holds
    // while the read stage is stalled.
    r3c_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_en    (in_acc),
        .i_slot  (cur_slot),
        .i_addr  (cur_col),
        .i_wdata ({i_in_red, i_in_green, i_in_blue}),
        .o_q     (mem_q)
    );

    // Two rows up lives in the next slot, one row up in the slot before.
    always_comb begin
        unique case (r_s1_slot)
            2'd0: begin
                row_top = mem_q[1];
                row_mid = mem_q[2];
            end
            2'd1: begin
                row_top = mem_q[2];
                row_mid = mem_q[0];
            end
            2'd2: begin
                row_top = mem_q[0];
                row_mid = mem_q[1];
            end
            default: begin
                row_top = mem_q[0];
                row_mid = mem_q[0];
            end
        endcase
    end

    r3c_job_seq u_job_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_s1_valid),
        .i_col        (r_s1_col),
        .i_row        (r_s1_row),
        .i_last_col   (r_s1_last_col),
        .i_last_row   (r_s1_last_row),
        .i_top        (row_top),
        .i_mid        (row_mid),
        .i_bot        (r_s1_pix),
        .o_load       (s1_adv),
        .o_valid      (job_valid),
        .i_ready      (mac_ready),
        .o_taps       (job_taps),
        .o_job        (job_info)
    );

    r3c_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (job_valid),
        .o_ready   (mac_ready),
        .i_taps    (job_taps),
        .i_job     (job_info),
        .i_taps_a  (r_cfg_taps_a),
        .i_taps_b  (r_cfg_taps_b),
        .i_contour (r_cfg_contour),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rgb     (res_rgb),
        .o_job     (res_job)
    );

    assign o_out_red    = res_rgb[0];
    assign o_out_green  = res_rgb[1];
    assign o_out_blue   = res_rgb[2];
    assign o_out_column = 10'(res_job.col);
    assign o_out_row    = 10'(res_job.row);
    assign o_run_last   = res_job.last;

`ifndef SYNTH
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_col) && $stable(mem_q)))
        else $error("stalled read stage lost its data");
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc) |=>
        ((r3c_pkg::SizeBits'(r_col) < w_size) && (r3c_pkg::SizeBits'(r_row) < h_size)))
        else $error("position left the frame");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot != 2'd3) && (!r_s1_valid || (r_s1_slot != 2'd3)))
        else $error("row slot out of range");
    a_row_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (cur_row == '0)) |-> (cur_slot == 2'd0))
        else $error("first row not in slot zero");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming RGB 3x3 convolution filter.
// ----------------------------------------------------------------------------
// Whole frames of pixels are streamed through the block under a number of
// register settings. A behavioral model of the filter, kept inside the bench,
// tracks the row store and the position counters and works out the results
// that each accepted pixel releases. Every result transaction is compared
// field by field with the oldest expected result. Both sides of the stream
// idle in short random bursts, and once the output holds off for a long
// stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------
module testbench;

    // Index outside the register map; writes to it must change nothing.
    localparam logic [r3c_pkg::CfgIdxBits-1:0] CFG_UNMAPPED = 3'd7;
    localparam logic [r3c_pkg::TapsABits-1:0]  TAPS_A_IDENT = 60'd256;
    localparam int                             RAND_ITEMS   = 340;
    localparam int                             PART_ITEMS   = 40;
    localparam int                             DRAIN_CYCLES = 30;
    localparam int                             LONG_HOLD    = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] column;
        logic [9:0] row;
        logic       last;
    } t_px_result;

    // One directed frame: sizes, coefficients, mode and the value that every
    // result of that frame must carry when it is obvious (-1 when not).
    typedef struct {
        logic [10:0]                   width;
        logic [10:0]                   height;
        logic [r3c_pkg::TapsABits-1:0] taps_a;
        logic [r3c_pkg::TapsBBits-1:0] taps_b;
        logic                          contour;
        int                            fixed_out;
    } t_frame_setup;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [7:0]                      i_in_red = '0;
    logic [7:0]                      i_in_green = '0;
    logic [7:0]                      i_in_blue = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [7:0]                      o_out_red;
    logic [7:0]                      o_out_green;
    logic [7:0]                      o_out_blue;
    logic [9:0]                      o_out_column;
    logic [9:0]                      o_out_row;
    logic                            o_run_last;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [r3c_pkg::CfgIdxBits-1:0]  i_cfg_index = '0;
    logic [r3c_pkg::CfgDataBits-1:0] i_cfg_data = '0;

    rgb_3x3_convolution_filter uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model state: its own copy of the registers, the row store and
    // the position of the next pixel.
    // ------------------------------------------------------------------
    logic [23:0]                   line_mem [3][r3c_pkg::MaxWidth];
    logic [10:0]                   img_width_reg;
    logic [10:0]                   img_height_reg;
    logic [r3c_pkg::TapsABits-1:0] taps_a_reg;
    logic [r3c_pkg::TapsBBits-1:0] taps_b_reg;
    logic                          contour_reg;
    int unsigned                   next_col;
    int unsigned                   next_row;

    t_px_result pending_px[$];
    int         fixed_value = -1;
    int         error_count = 0;
    int         pixels_sent = 0;
    int         results_seen = 0;
    int         frames_sent = 0;
    bit         quiet_tail = 1'b0;
    bit         hold_request = 1'b0;

    function automatic int unsigned clamp_size(logic [10:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic int signed tap_weight(int t);
        logic signed [r3c_pkg::CoefBits-1:0] raw;
        if (t < 5) raw = taps_a_reg[t*r3c_pkg::CoefBits +: r3c_pkg::CoefBits];
        else       raw = taps_b_reg[(t-5)*r3c_pkg::CoefBits +: r3c_pkg::CoefBits];
        return raw;
    endfunction

    // Filters pixel (x,y) with neighbors outside the frame replaced by the
    // centre color, and queues the resulting transaction.
    function automatic void queue_filtered(int x, int y, int w, int h);
        logic [23:0] centre;
        logic [23:0] win [9];
        logic [7:0]  chan [3];
        logic [7:0]  cv;
        logic [7:0]  v;
        int          nx;
        int          ny;
        longint      acc;
        bit          flat;
        t_px_result  res;
        centre = line_mem[y % 3][x];
        for (int t = 0; t < 9; t++) begin
            nx = x + r3c_pkg::TapDx[t];
            ny = y + r3c_pkg::TapDy[t];
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) win[t] = centre;
            else win[t] = line_mem[ny % 3][nx];
        end
        for (int ch = 0; ch < 3; ch++) begin
            cv = 8'(centre >> (16 - 8*ch));
            flat = 1'b1;
            acc = 0;
            for (int t = 0; t < 9; t++) begin
                v = 8'(win[t] >> (16 - 8*ch));
                if (v != cv) flat = 1'b0;
                acc += longint'(v) * tap_weight(t);
            end
            if (contour_reg && flat) chan[ch] = cv;
            else if (acc < 0) chan[ch] = 8'd0;
            else if ((acc >>> r3c_pkg::CoefFracBits) > r3c_pkg::PixMax) chan[ch] = 8'd255;
            else chan[ch] = 8'(acc >>> r3c_pkg::CoefFracBits);
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        res.column = 10'(x);
        res.row = 10'(y);
        res.last = 1'b0;
        if (fixed_value >= 0 && (chan[0] != fixed_value || chan[1] != fixed_value
                || chan[2] != fixed_value)) begin
            error_count++;
            if (error_count <= 10)
                $display("model disagrees with directed value %0d at (%0d,%0d)",
                    fixed_value, x, y);
        end
        pending_px.push_back(res);
    endfunction

    // Stores an accepted pixel and queues every result that it releases.
    function automatic void model_pixel(logic [23:0] rgb);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          xs [$];
        int          before_n;
        w = clamp_size(img_width_reg, r3c_pkg::MaxWidth);
        h = clamp_size(img_height_reg, r3c_pkg::MaxHeight);
        if (next_col >= w || next_row >= h) begin
            next_col = 0;
            next_row = 0;
        end
        c = next_col;
        r = next_row;
        line_mem[r % 3][c] = rgb;
        if (c >= 1) xs.push_back(c - 1);
        if (c == w - 1) xs.push_back(c);
        before_n = pending_px.size();
        foreach (xs[i]) begin
            if (r >= 1) queue_filtered(xs[i], r - 1, w, h);
            if (r == h - 1) queue_filtered(xs[i], r, w, h);
        end
        if (pending_px.size() > before_n) pending_px[$].last = 1'b1;
        next_col = c + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = r + 1;
            if (next_row >= h) next_row = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. Inputs change on the falling edge; the handshake is
    // evaluated with the values present at the rising edge.
    // ------------------------------------------------------------------
    task automatic idle_gap();
        int n;
        if (quiet_tail || $urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 4);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic push_pixel(logic [23:0] rgb);
        @(negedge i_clk);
        i_valid = 1'b1;
        {i_in_red, i_in_green, i_in_blue} = rgb;
        do @(posedge i_clk); while (!o_ready);
        model_pixel(rgb);
        pixels_sent++;
        idle_gap();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
        // Results may still be in flight for pixels that released none.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [r3c_pkg::CfgIdxBits-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            r3c_pkg::CFG_WIDTH:   img_width_reg = data[10:0];
            r3c_pkg::CFG_HEIGHT:  img_height_reg = data[10:0];
            r3c_pkg::CFG_TAPS_A:  taps_a_reg = data[r3c_pkg::TapsABits-1:0];
            r3c_pkg::CFG_TAPS_B:  taps_b_reg = data[r3c_pkg::TapsBBits-1:0];
            r3c_pkg::CFG_CONTOUR: contour_reg = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Size writes carry random junk above the 11 bits that the block keeps.
    task automatic program_frame(t_frame_setup s);
        write_reg(r3c_pkg::CFG_WIDTH, {11'($urandom), $urandom, 10'($urandom), s.width});
        write_reg(r3c_pkg::CFG_HEIGHT, {11'($urandom), $urandom, 10'($urandom), s.height});
        write_reg(r3c_pkg::CFG_TAPS_A, {4'($urandom), s.taps_a});
        write_reg(r3c_pkg::CFG_TAPS_B, {16'($urandom), s.taps_b});
        write_reg(r3c_pkg::CFG_CONTOUR, {$urandom, 31'($urandom), s.contour});
    endtask

    function automatic logic [59:0] rand_taps60();
        return {28'($urandom), $urandom};
    endfunction

    // Mostly mild kernels so that results land inside 0..255, now and then
    // raw random coefficients that drive the clamp both ways.
    function automatic t_frame_setup rand_setup();
        t_frame_setup s;
        logic [59:0] a;
        logic [47:0] b;
        s.width = 11'($urandom_range(1, 7));
        s.height = 11'($urandom_range(1, 5));
        if ($urandom_range(0, 9) == 0) s.width = 11'd0;
        if ($urandom_range(0, 9) == 0) s.height = 0;
        if ($urandom_range(0, 2) == 0) begin
            a = rand_taps60();
            b = {16'($urandom), $urandom};
        end else begin
            for (int t = 0; t < 5; t++) a[t*12 +: 12] = 12'($signed($urandom_range(0, 80)) - 24);
            for (int t = 0; t < 4; t++) b[t*12 +: 12] = 12'($signed($urandom_range(0, 80)) - 24);
        end
        s.taps_a = a;
        s.taps_b = b;
        s.contour = 1'($urandom_range(0, 1));
        s.fixed_out = -1;
        return s;
    endfunction

    // Directed frames: identity, all taps most negative, all taps most
    // positive on a flat frame in contour mode, and a zero size (acts as 1).
    localparam int DIR_FRAMES = 4;
    t_frame_setup dir_setup [DIR_FRAMES];
    int           dir_count [DIR_FRAMES] = '{9, 9, 4, 1};
    logic [23:0]  dir_pixels [23] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'h55AA55, 24'hAA55AA, 24'h808080, 24'h7F7F7F,
        24'hFFFFFF, 24'h010203, 24'hFF00FF, 24'h00FFFF, 24'h123456,
        24'hFEDCBA, 24'h800000, 24'h000080, 24'hFFFFFF,
        24'h3C3C3C, 24'h3C3C3C, 24'h3C3C3C, 24'h3C3C3C,
        24'hA5A5A5
    };

    initial begin
        t_frame_setup s;
        int           p;
        int           frames;
        bit           hold_done;

        dir_setup[0] = '{11'd3, 11'd3, TAPS_A_IDENT, 48'd0, 1'b0, -1};
        dir_setup[1] = '{11'd3, 11'd3, {5{12'h800}}, {4{12'h800}}, 1'b0, 0};
        dir_setup[2] = '{11'd2, 11'd2, {5{12'h7FF}}, {4{12'h7FF}}, 1'b1, 8'h3C};
        dir_setup[3] = '{11'd0, 11'd0, {5{12'h7FF}}, {4{12'h7FF}}, 1'b0, 255};

        img_width_reg = 11'd640;
        img_height_reg = 11'd480;
        taps_a_reg = TAPS_A_IDENT;
        taps_b_reg = '0;
        contour_reg = 1'b0;
        next_col = 0;
        next_row = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The unmapped index must leave all registers alone.
        write_reg(CFG_UNMAPPED, ~64'd0);

        // Directed frames. The identity frame is checked as the centre pixel
        // through the model; the others must give one fixed value each.
        p = 0;
        for (int f = 0; f < DIR_FRAMES; f++) begin
            program_frame(dir_setup[f]);
            fixed_value = dir_setup[f].fixed_out;
            for (int i = 0; i < dir_count[f]; i++) push_pixel(dir_pixels[p++]);
            wait_drained();
            frames_sent++;
        end
        fixed_value = -1;

        // Oversized frames, one row or one column, cut short. The size that
        // follows leaves the position outside the frame, so the next pixel
        // restarts the frame at (0,0).
        s = rand_setup();
        s.width = 11'd2047;
        s.height = 11'd1;
        program_frame(s);
        for (int i = 0; i < PART_ITEMS; i++) push_pixel(24'($urandom));
        wait_drained();
        s = rand_setup();
        s.width = 11'd1;
        s.height = 11'd2047;
        program_frame(s);
        for (int i = 0; i < PART_ITEMS; i++) push_pixel(24'($urandom));
        wait_drained();
        frames_sent += 2;

        // Random phases of whole frames. Pixels come from a small palette
        // half of the time so that flat neighborhoods occur often.
        p = 0;
        hold_done = 1'b0;
        while (p < RAND_ITEMS) begin
            s = rand_setup();
            if (p > RAND_ITEMS - 80) quiet_tail = 1'b1;
            if (p > 150 && !hold_done) begin
                // A full-sized frame behind the long hold-off fills the block.
                s.width = 11'd7;
                s.height = 11'd5;
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            program_frame(s);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                for (int i = 0; i < clamp_size(s.width, r3c_pkg::MaxWidth) *
                        clamp_size(s.height, r3c_pkg::MaxHeight); i++) begin
                    if ($urandom_range(0, 1)) push_pixel({3{8'($urandom_range(0, 1) * 8'hC3)}}
                        ^ {$urandom_range(0, 1) ? 24'h0 : 24'h010000});
                    else push_pixel(24'($urandom));
                    p++;
                end
                frames_sent++;
            end
            wait_drained();
        end

        $display("Streamed %0d pixels in %0d frames under many register settings,",
            pixels_sent, frames_sent);
        $display("checked %0d filtered results against the model.", results_seen);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off on request
    // so that the pipeline fills and the input stalls.
    // ------------------------------------------------------------------
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
                i_ready = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                i_ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_ready = 1'b1;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_px_result got;
        t_px_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_out_red, o_out_green, o_out_blue, o_out_column, o_out_row,
                o_run_last};
            results_seen++;
            if (pending_px.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = pending_px.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
